/* design/ps2_mouse_cursor_tracker_defines.svh */
// assertion macros for the ps2 mouse cursor tracker checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef PS2_MOUSE_CURSOR_TRACKER_DEFINES_SVH
`define PS2_MOUSE_CURSOR_TRACKER_DEFINES_SVH

// checked only while out of reset
`define PMCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define PMCT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* design/pmct_pkg.sv */
// constants and helpers for the ps2 mouse cursor tracker
// no dependencies
package pmct_pkg;

  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] RegMaxX = 1'b0;
  localparam logic [CfgIdxW-1:0] RegMaxY = 1'b1;

  localparam logic [7:0] MaxXReset    = 8'd79;
  localparam logic [7:0] MaxYReset    = 8'd23;
  localparam logic [7:0] HdrAlwaysOne = 8'h08;
  localparam logic [7:0] HdrOverflow  = 8'hC0;

  typedef logic signed [4:0] delta_t;

  // signed byte / 10, truncated toward zero; magnitude times 205 >> 11
  function automatic delta_t div10(input logic [7:0] b);
    logic [7:0]  mag;
    logic [15:0] prod;
    logic [4:0]  q;
    mag  = b[7] ? 8'(~b + 8'd1) : b;
    prod = 16'(mag) * 16'd205;
    q    = prod[15:11];
    return b[7] ? delta_t'(-q) : delta_t'(q);
  endfunction

  // clamp a signed position to 0..limit
  function automatic logic [7:0] clamp_pos(input logic signed [9:0] v,
                                           input logic [7:0] limit);
    logic [7:0] r;
    if (v < 0) begin
      r = 8'd0;
    end else if (v > $signed({2'b00, limit})) begin
      r = limit;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

/* design/ps2_mouse_cursor_tracker.sv */
// ps2 mouse cursor tracker top level
// depends on pmct_pkg
//
// usage:
//   input channel: one mouse byte per request on rx_byte_i, accepted when
//   in_valid_i is high and in_stall_o is low
//   output channel: one request per completed three-byte packet with the
//   clamped cursor position and the three button flags, taken when
//   out_valid_o is high and out_stall_i is low
//   headers without bit 3 set or with an overflow bit set are dropped
//   a packet's result is registered and shows the cycle after its third byte
//   throughput: one byte per cycle; the single output register is the only
//   buffer, so in_stall_o is high only while a result waits under stall
//   reset clears position, packet phase and output valid; the limits
//   return to 79 and 23
//   config writes (cfg_we_i) set max_x (index 0) or max_y (index 1) and
//   must be done only while the block is idle; the block does not enforce it
module ps2_mouse_cursor_tracker
  import pmct_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         cursor_x_o,
  output logic [7:0]         cursor_y_o,
  output logic               scroll_up_o,
  output logic               scroll_down_o,
  output logic               clear_request_o
);

  localparam logic [1:0] PhHeader = 2'd0;
  localparam logic [1:0] PhDx     = 2'd1;
  localparam logic [1:0] PhDy     = 2'd2;

  logic [7:0] max_x_q, max_y_q;
  logic [1:0] phase_q, phase_d;
  logic [7:0] header_q, header_d;
  logic [7:0] dx_byte_q, dx_byte_d;
  logic [7:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] cur_x_q, cur_y_q;
  logic [2:0] btn_q;
  logic       emit;
  logic       accept;
  logic signed [9:0] sum_x, sum_y;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign sum_x = $signed({2'b00, pos_x_q}) + 10'(div10(dx_byte_q));
  assign sum_y = $signed({2'b00, pos_y_q}) - 10'(div10(rx_byte_i));

  always_comb begin
    phase_d   = phase_q;
    header_d  = header_q;
    dx_byte_d = dx_byte_q;
    pos_x_d   = pos_x_q;
    pos_y_d   = pos_y_q;
    emit      = 1'b0;
    if (accept) begin
      case (phase_q)
        PhHeader: begin
          if (((rx_byte_i & HdrAlwaysOne) != 8'd0) && ((rx_byte_i & HdrOverflow) == 8'd0)) begin
            header_d = rx_byte_i;
            phase_d  = PhDx;
          end
        end
        PhDx: begin
          dx_byte_d = rx_byte_i;
          phase_d   = PhDy;
        end
        PhDy: begin
          pos_x_d = clamp_pos(sum_x, max_x_q);
          pos_y_d = clamp_pos(sum_y, max_y_q);
          phase_d = PhHeader;
          emit    = 1'b1;
        end
        default: begin
          phase_d = PhHeader;
        end
      endcase
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_x_q     <= MaxXReset;
      max_y_q     <= MaxYReset;
      phase_q     <= PhHeader;
      header_q    <= 8'd0;
      dx_byte_q   <= 8'd0;
      pos_x_q     <= 8'd0;
      pos_y_q     <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegMaxX: max_x_q <= cfg_data_i;
          RegMaxY: max_y_q <= cfg_data_i;
          default: ;
        endcase
      end
      phase_q     <= phase_d;
      header_q    <= header_d;
      dx_byte_q   <= dx_byte_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      cur_x_q <= pos_x_d;
      cur_y_q <= pos_y_d;
      btn_q   <= header_q[2:0];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cursor_x_o      = cur_x_q;
  assign cursor_y_o      = cur_y_q;
  assign scroll_up_o     = btn_q[0];
  assign scroll_down_o   = btn_q[1];
  assign clear_request_o = btn_q[2];

endmodule

/* design/pmct_checker.sv */
// port-level checks for the ps2 mouse cursor tracker, bound to the top level
// depends on pmct_pkg and ps2_mouse_cursor_tracker_defines.svh
`include "ps2_mouse_cursor_tracker_defines.svh"

module pmct_checker
  import pmct_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [7:0]         cursor_x_o,
  input logic [7:0]         cursor_y_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // no result held during reset
  `PMCT_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_o, "output valid during reset")

  // input only stalls behind a waiting result
  `PMCT_ASSERT(a_stall_cause, in_stall_o |-> (out_valid_o && out_stall_i), "input stalled without a waiting result")

  // a fresh result needs a byte taken the cycle before
  `PMCT_ASSERT(a_result_src, (!out_valid_o || !out_stall_i) |=> (!out_valid_o || $past(in_acc)), "result without an accepted byte")

  // stalled result holds
  `PMCT_ASSERT(a_out_hold, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(cursor_x_o) && $stable(cursor_y_o)), "stalled result changed")

endmodule

bind ps2_mouse_cursor_tracker pmct_checker u_pmct_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .cursor_x_o  (cursor_x_o),
  .cursor_y_o  (cursor_y_o)
);
